/* rtl/cgp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and table builders for the RGB color grading pipeline.
// Depends on nothing; every other file of the block imports it.
package cgp_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = ONE / 2;
    localparam int POW_N     = 256;
    localparam int IDX_W     = $clog2(POW_N);
    localparam int TI_W      = $clog2(POW_N + 1);
    localparam int P_W       = FRAC_BITS + IDX_W;
    localparam int TAB_W     = FRAC_BITS + 2;
    localparam int OUT_W     = FRAC_BITS + 1;

    localparam int LUMA_R = 871;
    localparam int LUMA_G = 2929;
    localparam int LUMA_B = 296;
    localparam int TEMP_K = 410;
    localparam int TINT_K = 205;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_GAMMA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIDTONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TONE      = 3'd7;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
    } pix_out_t;

    typedef logic [TAB_W-1:0] tab_t [0:POW_N];

    function automatic logic [OUT_W-1:0] clamp_unit(input logic signed [39:0] v);
        logic [OUT_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > 40'(ONE))
            r = OUT_W'(ONE);
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h1 << 62;
        for (int n = 0; n < 32; n++)
            if (b > v)
                b = b >> 2;
        for (int n = 0; n < 32; n++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2 of 1+i/N by repeated squaring, one result bit per squaring.
    function automatic tab_t build_log_tab();
        tab_t t;
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] ii;
        for (int i = 0; i < POW_N; i++) begin
            ii = 64'(i);
            y  = 64'h4000_0000 + ((ii << 30) / POW_N);
            r  = '0;
            for (int j = 0; j < FRAC_BITS; j++) begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= 64'h8000_0000) begin
                    y = y >> 1;
                    r = r | 64'h1;
                end
            end
            t[i] = r[TAB_W-1:0];
        end
        t[POW_N] = TAB_W'(ONE);
        return t;
    endfunction

    // 2^(i/N) as a product of repeated square roots of two, rounded half up.
    function automatic tab_t build_exp_tab();
        tab_t t;
        logic [63:0] c [0:30];
        logic [63:0] e;
        logic [63:0] f;
        logic [63:0] ii;
        c[0] = 64'h8000_0000;
        for (int j = 1; j <= 30; j++)
            c[j] = isqrt64(c[j-1] << 30);
        for (int i = 0; i < POW_N; i++) begin
            ii = 64'(i);
            f  = (ii << 30) / POW_N;
            e  = 64'h4000_0000;
            for (int j = 1; j <= 30; j++)
                if (f[30-j])
                    e = (e * c[j]) >> 30;
            e    = (e + (64'h1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            t[i] = e[TAB_W-1:0];
        end
        t[POW_N] = TAB_W'(2 * ONE);
        return t;
    endfunction

endpackage

/* rtl/cgp_chan.sv */
`timescale 1ns / 1ps
// One color channel front end: exposure, lift, table based power, gain and clamp.
// Nine register stages; uses cgp_pkg for the log and exp tables.
module cgp_chan
    import cgp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             valid,
    input  logic [15:0]      x,
    input  logic [19:0]      exposure,
    input  logic [15:0]      lift,
    input  logic [15:0]      inv_gamma,
    input  logic [15:0]      gain,
    output logic             done_valid,
    output logic [OUT_W-1:0] level
);

    localparam tab_t LOG_TAB = build_log_tab();
    localparam tab_t EXP_TAB = build_exp_tab();
    localparam int NSTG = 9;

    logic [NSTG-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], valid};
    end

    assign done_valid = vld_reg[NSTG-1];

    // Stage 1: exposure and lift.
    logic [35:0]        s1_prod;
    logic signed [25:0] s1_v_next, s1_v_reg;
    // Stage 2: leading one.
    logic               s2_pow_next, s2_pow_reg;
    logic [4:0]         s2_msb_next, s2_msb_reg;
    logic signed [25:0] s2_v_reg;
    // Stage 3: mantissa.
    logic [36:0]          s3_sh;
    logic [FRAC_BITS-1:0] s3_m_next, s3_m_reg;
    logic [4:0]           s3_msb_reg;
    logic signed [25:0]   s3_v_reg;
    logic                 s3_pow_reg;
    // Stage 4: log2.
    logic [P_W-1:0]       s4_p;
    logic [TI_W-1:0]      s4_i0, s4_i1;
    logic signed [14:0]   s4_dlt;
    logic signed [27:0]   s4_dr;
    logic signed [16:0]   s4_ip;
    logic signed [6:0]    s4_ex;
    logic signed [18:0]   s4_lg_next, s4_lg_reg;
    logic signed [25:0]   s4_v_reg;
    logic                 s4_pow_reg;
    // Stage 5: scale by the reciprocal gamma.
    logic signed [35:0]   s5_prod;
    logic signed [23:0]   s5_p_reg;
    logic signed [25:0]   s5_v_reg;
    logic                 s5_pow_reg;
    // Stage 6: exp2 of the fraction.
    logic [P_W-1:0]       s6_p;
    logic [TI_W-1:0]      s6_i0, s6_i1;
    logic signed [14:0]   s6_dlt;
    logic signed [27:0]   s6_dr;
    logic signed [16:0]   s6_ip;
    logic [TAB_W-1:0]     s6_mant_reg;
    logic signed [11:0]   s6_k_reg;
    logic signed [25:0]   s6_v_reg;
    logic                 s6_pow_reg;
    // Stage 7: integer shift and power select.
    logic [11:0]          s7_nk;
    logic [26:0]          s7_sh, s7_pw;
    logic signed [27:0]   s7_w_next, s7_w_reg;
    // Stage 8 and 9: gain and clamp.
    logic signed [44:0]   s8_prod_reg;
    logic [OUT_W-1:0]     s9_level_reg;

    always_comb
    begin
        s1_prod   = 36'(x) * 36'(exposure);
        s1_v_next = $signed({2'b00, s1_prod[FRAC_BITS +: 24]}) + 26'(signed'(lift));

        s2_pow_next = (inv_gamma != 16'(ONE)) && !s1_v_reg[25] && (s1_v_reg != '0);
        s2_msb_next = '0;
        for (int n = 0; n < 25; n++)
            if (s1_v_reg[n])
                s2_msb_next = 5'(n);

        s3_sh     = ({12'b0, s2_v_reg[24:0]} << FRAC_BITS) >> s2_msb_reg;
        s3_m_next = s3_sh[FRAC_BITS-1:0];

        s4_p       = P_W'(s3_m_reg) * P_W'(POW_N);
        s4_i0      = {1'b0, s4_p[FRAC_BITS +: IDX_W]};
        s4_i1      = s4_i0 + TI_W'(1);
        s4_dlt     = $signed({1'b0, LOG_TAB[s4_i1]}) - $signed({1'b0, LOG_TAB[s4_i0]});
        s4_dr      = s4_dlt * $signed({1'b0, s4_p[FRAC_BITS-1:0]});
        s4_ip      = $signed({3'b000, LOG_TAB[s4_i0]})
                   + $signed({s4_dr[27], s4_dr[27:FRAC_BITS]});
        s4_ex      = $signed({2'b00, s3_msb_reg}) - $signed(7'(FRAC_BITS));
        s4_lg_next = $signed({s4_ex, {FRAC_BITS{1'b0}}}) + 19'(s4_ip);

        s5_prod = s4_lg_reg * $signed({1'b0, inv_gamma});

        s6_p   = P_W'(s5_p_reg[FRAC_BITS-1:0]) * P_W'(POW_N);
        s6_i0  = {1'b0, s6_p[FRAC_BITS +: IDX_W]};
        s6_i1  = s6_i0 + TI_W'(1);
        s6_dlt = $signed({1'b0, EXP_TAB[s6_i1]}) - $signed({1'b0, EXP_TAB[s6_i0]});
        s6_dr  = s6_dlt * $signed({1'b0, s6_p[FRAC_BITS-1:0]});
        s6_ip  = $signed({3'b000, EXP_TAB[s6_i0]})
               + $signed({s6_dr[27], s6_dr[27:FRAC_BITS]});

        // Positive exponents saturate at 2^(2F+2); negative ones truncate.
        s7_nk = 12'(-s6_k_reg);
        s7_sh = '0;
        if (!s6_k_reg[11]) begin
            if (s6_k_reg > 12'(FRAC_BITS + 1))
                s7_pw = 27'h1 << (2 * FRAC_BITS + 2);
            else begin
                s7_sh = 27'(s6_mant_reg) << s6_k_reg[3:0];
                s7_pw = (s7_sh > (27'h1 << (2 * FRAC_BITS + 2)))
                      ? (27'h1 << (2 * FRAC_BITS + 2)) : s7_sh;
            end
        end else begin
            if (s7_nk > 12'(FRAC_BITS + 1))
                s7_pw = '0;
            else
                s7_pw = 27'(s6_mant_reg) >> s7_nk[3:0];
        end
        s7_w_next = s6_pow_reg ? $signed({1'b0, s7_pw}) : 28'(s6_v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_v_reg     <= s1_v_next;
            s2_v_reg     <= s1_v_reg;
            s2_msb_reg   <= s2_msb_next;
            s2_pow_reg   <= s2_pow_next;
            s3_m_reg     <= s3_m_next;
            s3_msb_reg   <= s2_msb_reg;
            s3_v_reg     <= s2_v_reg;
            s3_pow_reg   <= s2_pow_reg;
            s4_lg_reg    <= s4_lg_next;
            s4_v_reg     <= s3_v_reg;
            s4_pow_reg   <= s3_pow_reg;
            s5_p_reg     <= s5_prod[FRAC_BITS +: 24];
            s5_v_reg     <= s4_v_reg;
            s5_pow_reg   <= s4_pow_reg;
            s6_mant_reg  <= s6_ip[TAB_W-1:0];
            s6_k_reg     <= s5_p_reg[23:FRAC_BITS];
            s6_v_reg     <= s5_v_reg;
            s6_pow_reg   <= s5_pow_reg;
            s7_w_reg     <= s7_w_next;
            s8_prod_reg  <= s7_w_reg * $signed({1'b0, gain});
            s9_level_reg <= clamp_unit(40'($signed(s8_prod_reg[44:FRAC_BITS])));
        end
    end

    assign level = s9_level_reg;

endmodule

/* rtl/cgp_tone.sv */
`timescale 1ns / 1ps
// Tone stages: saturation, contrast, luma weighted tints and temperature/tint.
// Eight register stages, the last one is the output word register; uses cgp_pkg.
module cgp_tone
    import cgp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             valid,
    input  logic [OUT_W-1:0] red,
    input  logic [OUT_W-1:0] green,
    input  logic [OUT_W-1:0] blue,
    input  logic [63:0]      tone,
    input  logic [47:0]      shadow,
    input  logic [47:0]      midtone,
    input  logic [47:0]      highlight,
    output logic             done_valid,
    output pix_out_t         graded
);

    localparam int NSTG = 8;

    logic [NSTG-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], valid};
    end

    assign done_valid = vld_reg[NSTG-1];

    logic [15:0] sat, con;
    logic signed [15:0] temp, tint;
    assign sat  = tone[15:0];
    assign con  = tone[31:16];
    assign temp = signed'(tone[47:32]);
    assign tint = signed'(tone[63:48]);

    logic [24:0]            t1_sum;
    logic [OUT_W-1:0]       t1_y_reg;
    logic [OUT_W-1:0]       t1_c_reg [3];
    logic signed [13:0]     t2_d [3];
    logic signed [30:0]     t2_p [3];
    logic signed [18:0]     t2_c_next [3], t2_c_reg [3];
    logic signed [19:0]     t3_d [3];
    logic signed [36:0]     t3_p [3];
    logic signed [18:0]     t3_c_next [3], t3_c_reg [3];
    logic signed [31:0]     t4_sum;
    logic signed [19:0]     t4_y_reg;
    logic signed [18:0]     t4_c_reg [3];
    logic signed [20:0]     t5_two_y;
    logic [OUT_W-1:0]       t5_lo, t5_hi;
    logic [OUT_W:0]         t5_sw, t5_mw;
    logic [OUT_W:0]         t5_sw_reg, t5_mw_reg, t5_hw_reg;
    logic signed [18:0]     t5_c_reg [3];
    logic signed [29:0]     t6_ps [3], t6_pm [3], t6_ph [3];
    logic signed [17:0]     t6_s_reg [3], t6_m_reg [3], t6_h_reg [3];
    logic signed [18:0]     t6_c_reg [3];
    logic signed [20:0]     t7_sum [3];
    logic [OUT_W-1:0]       t7_c_reg [3];
    logic signed [26:0]     t8_pt, t8_pn, t8_ph;
    logic signed [16:0]     t8_dt, t8_dn, t8_dh;
    logic signed [16:0]     t8_r, t8_g, t8_b;
    pix_out_t               t8_out_reg;

    always_comb
    begin
        t1_sum = 25'(LUMA_R) * 25'(red) + 25'(LUMA_G) * 25'(green)
               + 25'(LUMA_B) * 25'(blue);

        for (int l = 0; l < 3; l++) begin
            t2_d[l]      = $signed({1'b0, t1_c_reg[l]}) - $signed({1'b0, t1_y_reg});
            t2_p[l]      = $signed({1'b0, sat}) * t2_d[l];
            t2_c_next[l] = $signed({6'b0, t1_y_reg}) + t2_p[l][30:FRAC_BITS];

            // Neutral contrast skips the stage, including its clamp.
            t3_d[l] = 20'(t2_c_reg[l]) - 20'sd2048;
            t3_p[l] = t3_d[l] * $signed({1'b0, con});
            if (con != 16'(ONE))
                t3_c_next[l] = $signed({6'b0,
                                        clamp_unit(40'($signed(t3_p[l][36:FRAC_BITS]))
                                                   + 40'(HALF))});
            else
                t3_c_next[l] = t2_c_reg[l];
        end

        t4_sum = 32'(t3_c_reg[0]) * 32'(LUMA_R) + 32'(t3_c_reg[1]) * 32'(LUMA_G)
               + 32'(t3_c_reg[2]) * 32'(LUMA_B);

        t5_two_y = {t4_y_reg, 1'b0};
        t5_lo    = clamp_unit(40'(t5_two_y));
        t5_hi    = clamp_unit(40'(t5_two_y) - 40'(ONE));
        t5_sw    = (OUT_W + 1)'(ONE) - {1'b0, t5_lo};
        t5_mw    = (OUT_W + 1)'(ONE) - t5_sw - {1'b0, t5_hi};

        for (int l = 0; l < 3; l++) begin
            t6_ps[l] = $signed(shadow[16*l +: 16])    * $signed({1'b0, t5_sw_reg});
            t6_pm[l] = $signed(midtone[16*l +: 16])   * $signed({1'b0, t5_mw_reg});
            t6_ph[l] = $signed(highlight[16*l +: 16]) * $signed({1'b0, t5_hw_reg});
            t7_sum[l] = 21'(t6_c_reg[l]) + 21'(t6_s_reg[l]) + 21'(t6_m_reg[l])
                      + 21'(t6_h_reg[l]);
        end

        t8_pt = temp * 27'sd410;
        t8_pn = tint * 27'sd410;
        t8_ph = tint * 27'sd205;
        t8_dt = 17'($signed(t8_pt[26:FRAC_BITS]));
        t8_dn = 17'($signed(t8_pn[26:FRAC_BITS]));
        t8_dh = 17'($signed(t8_ph[26:FRAC_BITS]));
        t8_r  = $signed({4'b0, t7_c_reg[0]}) + t8_dt + t8_dh;
        t8_g  = $signed({4'b0, t7_c_reg[1]}) - t8_dn;
        t8_b  = $signed({4'b0, t7_c_reg[2]}) + t8_dh - t8_dt;
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            t1_y_reg    <= t1_sum[24:FRAC_BITS];
            t1_c_reg[0] <= red;
            t1_c_reg[1] <= green;
            t1_c_reg[2] <= blue;
            t4_y_reg    <= t4_sum[31:FRAC_BITS];
            t5_sw_reg   <= t5_sw;
            t5_mw_reg   <= t5_mw;
            t5_hw_reg   <= {1'b0, t5_hi};
            for (int l = 0; l < 3; l++) begin
                t2_c_reg[l] <= t2_c_next[l];
                t3_c_reg[l] <= t3_c_next[l];
                t4_c_reg[l] <= t3_c_reg[l];
                t5_c_reg[l] <= t4_c_reg[l];
                t6_c_reg[l] <= t5_c_reg[l];
                t6_s_reg[l] <= t6_ps[l][29:FRAC_BITS];
                t6_m_reg[l] <= t6_pm[l][29:FRAC_BITS];
                t6_h_reg[l] <= t6_ph[l][29:FRAC_BITS];
                t7_c_reg[l] <= clamp_unit(40'(t7_sum[l]));
            end
            t8_out_reg.red_out   <= clamp_unit(40'(t8_r));
            t8_out_reg.green_out <= clamp_unit(40'(t8_g));
            t8_out_reg.blue_out  <= clamp_unit(40'(t8_b));
        end
    end

    assign graded = t8_out_reg;

endmodule

/* rtl/rgb_color_grading_pipeline_unit.sv */
`timescale 1ns / 1ps
// RGB color grading pipeline: lift, gamma, gain, saturation, contrast, tints.
// The pipeline is the 9 channel stages followed by the 8 tone stages; it takes one
// pixel per cycle in steady state while no finished word is stalled.
// The whole pipeline advances together and holds while a finished word is stalled.
// Reset (rst_n low, asynchronous) empties the pipeline and loads neutral settings.
module rgb_color_grading_pipeline_unit
    import cgp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  pix_in_t              pixel,
    output logic                 graded_valid,
    input  logic                 graded_stall,
    output pix_out_t             graded,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [47:0] lift_reg, inv_gamma_reg, gain_reg;
    logic [47:0] shadow_reg, midtone_reg, highlight_reg;
    logic [19:0] exposure_reg;
    logic [63:0] tone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lift_reg      <= '0;
            inv_gamma_reg <= 48'h1000_1000_1000;
            gain_reg      <= 48'h1000_1000_1000;
            shadow_reg    <= '0;
            midtone_reg   <= '0;
            highlight_reg <= '0;
            exposure_reg  <= 20'(ONE);
            tone_reg      <= 64'h1000_1000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LIFT:      lift_reg      <= cfg_data[47:0];
                REG_INV_GAMMA: inv_gamma_reg <= cfg_data[47:0];
                REG_GAIN:      gain_reg      <= cfg_data[47:0];
                REG_SHADOW:    shadow_reg    <= cfg_data[47:0];
                REG_MIDTONE:   midtone_reg   <= cfg_data[47:0];
                REG_HIGHLIGHT: highlight_reg <= cfg_data[47:0];
                REG_EXPOSURE:  exposure_reg  <= cfg_data[19:0];
                REG_TONE:      tone_reg      <= cfg_data;
            endcase
        end
    end

    logic adv;
    logic [2:0] chan_valid;
    logic [OUT_W-1:0] chan_level [3];
    logic [15:0] chan_x [3];

    assign adv         = !(graded_valid && graded_stall);
    assign pixel_stall = !adv;
    assign chan_x[0]   = pixel.red_in;
    assign chan_x[1]   = pixel.green_in;
    assign chan_x[2]   = pixel.blue_in;

    for (genvar l = 0; l < 3; l++) begin : g_chan
        cgp_chan u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .valid      (pixel_valid),
            .x          (chan_x[l]),
            .exposure   (exposure_reg),
            .lift       (lift_reg[16*l +: 16]),
            .inv_gamma  (inv_gamma_reg[16*l +: 16]),
            .gain       (gain_reg[16*l +: 16]),
            .done_valid (chan_valid[l]),
            .level      (chan_level[l])
        );
    end

    // All three lanes carry the same valid bits; they are combined for the tone stages.
    cgp_tone u_tone (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .valid      (chan_valid[0] & chan_valid[1] & chan_valid[2]),
        .red        (chan_level[0]),
        .green      (chan_level[1]),
        .blue       (chan_level[2]),
        .tone       (tone_reg),
        .shadow     (shadow_reg),
        .midtone    (midtone_reg),
        .highlight  (highlight_reg),
        .done_valid (graded_valid),
        .graded     (graded)
    );

endmodule

/* rtl/cgp_checker.sv */
`timescale 1ns / 1ps
// Port level checks for the color grading pipeline, bound to the top level.
// Depends on cgp_pkg for the word types.
module cgp_checker
    import cgp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pixel_stall,
    input logic                 graded_valid,
    input logic                 graded_stall,
    input pix_out_t             graded
);

    // The input side is held back only by a stalled finished word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall == (graded_valid && graded_stall))
        else $error("pixel stall without a stalled graded word");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        graded_valid |-> (graded.red_out <= OUT_W'(ONE)) && (graded.green_out <= OUT_W'(ONE))
                         && (graded.blue_out <= OUT_W'(ONE)))
        else $error("graded value above one");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        graded_valid && graded_stall |=> graded_valid)
        else $error("graded word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        graded_valid && graded_stall |=> $stable(graded))
        else $error("graded word changed while stalled");

endmodule

bind rgb_color_grading_pipeline_unit cgp_checker u_cgp_checker (.*);

/* bench/rgb_color_grading_pipeline_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rgb_color_grading_pipeline_unit: a bit-exact grading
// predictor, random pixel and register stimulus, and checks on every graded word.
// Depends on cgp_pkg and the RTL of the block only.
module rgb_color_grading_pipeline_unit_tb;
    import cgp_pkg::*;

    localparam int  HALF_PERIOD  = 10;
    localparam int  IDLE_LIMIT   = 5000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  NTAB         = 256;
    localparam longint UNITY     = 4096;
    localparam longint PW_CAP    = longint'(1) << 26;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_stall;
    pix_in_t              pixel = '0;
    logic                 graded_valid;
    logic                 graded_stall = 1'b0;
    pix_out_t             graded;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LIFT;
    logic [63:0]          cfg_data = '0;

    // Register copies as the block holds them, and the power tables.
    logic [63:0] grade_regs [0:7];
    longint      log2_frac [0:NTAB];
    longint      exp2_frac [0:NTAB];

    pix_out_t    graded_expected [$];
    int          fail_count = 0;
    int          pixels_sent = 0;
    int          words_checked = 0;
    int          idle_cycles = 0;
    int          stall_pct = 0;
    int          stall_period = 1;
    int          stall_cycle = 0;
    int          burst_left = 0;
    int          max_gap = 0;

    rgb_color_grading_pipeline_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .graded_valid (graded_valid),
        .graded_stall (graded_stall),
        .graded       (graded),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    task automatic build_pow_tables();
        longint unsigned sq [0:30];
        longint unsigned y;
        longint unsigned acc;
        longint unsigned frac;
        longint unsigned bits;
        sq[0] = longint'(1) << 31;
        for (int j = 1; j <= 30; j++)
            sq[j] = root_floor(sq[j-1] << 30);
        for (int i = 0; i < NTAB; i++) begin
            y = (longint'(1) << 30) + ((longint'(i) << 30) / NTAB);
            bits = 0;
            for (int j = 0; j < 12; j++) begin
                y = (y * y) >> 30;
                bits = bits << 1;
                if (y >= (longint'(1) << 31)) begin
                    y = y >> 1;
                    bits = bits | 1;
                end
            end
            log2_frac[i] = longint'(bits);
            frac = (longint'(i) << 30) / NTAB;
            acc = longint'(1) << 30;
            for (int j = 1; j <= 30; j++)
                if (frac[30-j])
                    acc = (acc * sq[j]) >> 30;
            exp2_frac[i] = longint'((acc + (longint'(1) << 17)) >> 18);
        end
        log2_frac[NTAB] = UNITY;
        exp2_frac[NTAB] = 2 * UNITY;
    endtask

    function automatic longint field_u(input logic [63:0] r, input int n);
        return longint'(r[16*n +: 16]);
    endfunction

    function automatic longint field_s(input logic [63:0] r, input int n);
        logic signed [15:0] f;
        f = r[16*n +: 16];
        return longint'(f);
    endfunction

    function automatic longint unit_clamp(input longint v);
        return (v < 0) ? 0 : ((v > UNITY) ? UNITY : v);
    endfunction

    function automatic longint table_lookup(input bit use_log, input longint q);
        longint p;
        longint i;
        longint r;
        longint a;
        longint b;
        p = q * NTAB;
        i = p >>> 12;
        r = p & (UNITY - 1);
        if (i < 0) i = 0;
        if (i > NTAB - 1) i = NTAB - 1;
        a = use_log ? log2_frac[i] : exp2_frac[i];
        b = use_log ? log2_frac[i+1] : exp2_frac[i+1];
        return a + (((b - a) * r) >>> 12);
    endfunction

    // v to the power ig via exp2(ig * log2(v)).
    function automatic longint gamma_power(input longint v, input longint ig);
        int     msb;
        longint m;
        longint lg;
        longint p;
        longint k;
        longint f;
        longint mant;
        msb = 0;
        while (msb < 62 && (v >> (msb + 1)) != 0)
            msb++;
        m = ((v << 12) >> msb) - UNITY;
        lg = longint'(msb - 12) * UNITY + table_lookup(1'b1, m);
        p = (lg * ig) >>> 12;
        k = p >>> 12;
        f = p - k * UNITY;
        mant = table_lookup(1'b0, f);
        if (k >= 0) begin
            if (k > 13)
                return PW_CAP;
            mant = mant << k;
            return (mant > PW_CAP) ? PW_CAP : mant;
        end
        if (-k > 13)
            return 0;
        return mant >> (-k);
    endfunction

    function automatic longint luma_of(input longint c [3]);
        return (871 * c[0] + 2929 * c[1] + 296 * c[2]) >>> 12;
    endfunction

    function automatic pix_out_t grade_pixel(input pix_in_t p);
        longint   c [3];
        longint   chan [3];
        longint   v;
        longint   ig;
        longint   y;
        longint   sw;
        longint   hw;
        longint   mw;
        longint   sat;
        longint   con;
        longint   d_temp;
        longint   d_tint;
        longint   d_half;
        pix_out_t o;
        chan[0] = longint'(p.red_in);
        chan[1] = longint'(p.green_in);
        chan[2] = longint'(p.blue_in);
        for (int i = 0; i < 3; i++) begin
            v = (chan[i] * longint'(grade_regs[REG_EXPOSURE][19:0])) >> 12;
            v += field_s(grade_regs[REG_LIFT], i);
            ig = field_u(grade_regs[REG_INV_GAMMA], i);
            if (ig != UNITY && v > 0)
                v = gamma_power(v, ig);
            v = (v * field_u(grade_regs[REG_GAIN], i)) >>> 12;
            c[i] = unit_clamp(v);
        end
        sat = field_u(grade_regs[REG_TONE], 0);
        if (sat != UNITY) begin
            y = luma_of(c);
            for (int i = 0; i < 3; i++)
                c[i] = y + ((sat * (c[i] - y)) >>> 12);
        end
        // Neutral contrast bypasses the stage and its clamp entirely.
        con = field_u(grade_regs[REG_TONE], 1);
        if (con != UNITY)
            for (int i = 0; i < 3; i++)
                c[i] = unit_clamp(UNITY / 2 + (((c[i] - UNITY / 2) * con) >>> 12));
        y = luma_of(c);
        sw = UNITY - unit_clamp(2 * y);
        hw = unit_clamp(2 * y - UNITY);
        mw = UNITY - sw - hw;
        for (int i = 0; i < 3; i++) begin
            c[i] += (field_s(grade_regs[REG_SHADOW], i) * sw) >>> 12;
            c[i] += (field_s(grade_regs[REG_MIDTONE], i) * mw) >>> 12;
            c[i] += (field_s(grade_regs[REG_HIGHLIGHT], i) * hw) >>> 12;
            c[i] = unit_clamp(c[i]);
        end
        d_temp = (field_s(grade_regs[REG_TONE], 2) * 410) >>> 12;
        d_tint = (field_s(grade_regs[REG_TONE], 3) * 410) >>> 12;
        d_half = (field_s(grade_regs[REG_TONE], 3) * 205) >>> 12;
        o.red_out   = OUT_W'(unit_clamp(c[0] + d_temp + d_half));
        o.green_out = OUT_W'(unit_clamp(c[1] - d_tint));
        o.blue_out  = OUT_W'(unit_clamp(c[2] + d_half - d_temp));
        return o;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_EXPOSURE)
            grade_regs[idx] = data & 64'hF_FFFF;
        else if (idx == REG_TONE)
            grade_regs[idx] = data;
        else
            grade_regs[idx] = data & 64'hFFFF_FFFF_FFFF;
    endtask

    task automatic send_pixel(input pix_in_t p);
        int gap;
        pixel       <= p;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (pixel_stall);
        graded_expected.push_back(grade_pixel(p));
        pixels_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(30);
            gap = (max_gap == 0) ? 0 : $urandom_range(max_gap);
            if (gap > 0) begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Settles the pipeline so registers may be rewritten safely.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (graded_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic pix_in_t make_pixel(input int r, input int g, input int b);
        pix_in_t p;
        p.red_in   = 16'(r);
        p.green_in = 16'(g);
        p.blue_in  = 16'(b);
        return p;
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t p;
        if ($urandom_range(3) == 0)
            p = make_pixel($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        else
            p = make_pixel($urandom_range(5000), $urandom_range(5000), $urandom_range(5000));
        return p;
    endfunction

    function automatic logic [15:0] random_field(input bit is_signed);
        logic [15:0] f;
        case ($urandom_range(7))
            0: f = 16'h0000;
            1: f = 16'hFFFF;
            2: f = 16'h1000;
            3: f = 16'($urandom_range(65535));
            default: f = is_signed ? 16'($signed(12'($urandom_range(4095)))) :
                                     16'($urandom_range(2048, 10240));
        endcase
        return f;
    endfunction

    function automatic logic [63:0] random_triplet(input bit is_signed);
        return {16'($urandom), random_field(is_signed), random_field(is_signed),
                random_field(is_signed)};
    endfunction

    task automatic load_all(input logic [63:0] lift, input logic [63:0] igam,
                            input logic [63:0] gain, input logic [63:0] sh,
                            input logic [63:0] mid, input logic [63:0] hi,
                            input logic [63:0] expo, input logic [63:0] tone);
        write_reg(REG_LIFT, lift);
        write_reg(REG_INV_GAMMA, igam);
        write_reg(REG_GAIN, gain);
        write_reg(REG_SHADOW, sh);
        write_reg(REG_MIDTONE, mid);
        write_reg(REG_HIGHLIGHT, hi);
        write_reg(REG_EXPOSURE, expo);
        write_reg(REG_TONE, tone);
    endtask

    task automatic test_neutral_extremes();
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(65535, 65535, 65535));
        send_pixel(make_pixel(4096, 4096, 4096));
        send_pixel(make_pixel(1, 2048, 4095));
        send_pixel(make_pixel(43690, 21845, 32768));
        send_pixel(make_pixel(21845, 43690, 1));
        wait_idle();
    endtask

    // Zero, neutral and steep inverse gamma, negative lift and a huge exposure.
    task automatic test_gamma_cases();
        load_all({16'h0, 16'hF000, 16'h0100, 16'h8000}, {16'h0, 16'hFFFF, 16'h1000, 16'h0000},
                 {16'h0, 16'hFFFF, 16'h1000, 16'h2000}, 0, 0, 0, 64'hF_FFFF, 64'h1000_1000);
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(65535, 65535, 65535));
        send_pixel(make_pixel(1, 1, 1));
        send_pixel(make_pixel(300, 7, 4096));
        wait_idle();
        write_reg(REG_EXPOSURE, 64'h1000);
        write_reg(REG_INV_GAMMA, {16'h0, 16'h0800, 16'h1C00, 16'h3000});
        write_reg(REG_LIFT, {16'h0, 16'h0200, 16'h7FFF, 16'hFF00});
        send_pixel(make_pixel(100, 100, 100));
        send_pixel(make_pixel(2048, 3000, 500));
        send_pixel(make_pixel(65535, 0, 12));
        wait_idle();
    endtask

    // Oversaturation with neutral contrast leaves values out of range for the wheels.
    task automatic test_tone_cases();
        load_all(0, 64'h1000_1000_1000, 64'h1000_1000_1000, {16'h0, 16'hFC00, 16'h0400, 16'h0300},
                 {16'h0, 16'h0200, 16'hFE00, 16'h8000}, {16'h0, 16'h7FFF, 16'h0100, 16'hF000},
                 64'h1000, 64'h0000_0000_1000_3000);
        send_pixel(make_pixel(4096, 0, 0));
        send_pixel(make_pixel(500, 3800, 200));
        send_pixel(make_pixel(2048, 2048, 2048));
        wait_idle();
        write_reg(REG_TONE, 64'h8000_7FFF_1800_0000);
        send_pixel(make_pixel(4096, 100, 3000));
        send_pixel(make_pixel(1000, 1000, 1000));
        wait_idle();
        write_reg(REG_TONE, 64'h7FFF_8000_FFFF_FFFF);
        send_pixel(make_pixel(3000, 2000, 1000));
        send_pixel(make_pixel(0, 4096, 65535));
        wait_idle();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            if (ph == 0)
                load_all('0, '0, '0, '0, '0, '0, '0, '0);
            else if (ph == 1)
                load_all('1, '1, '1, '1, '1, '1, '1, '1);
            else
                load_all(random_triplet(1'b1), random_triplet(1'b0), random_triplet(1'b0),
                         random_triplet(1'b1), random_triplet(1'b1), random_triplet(1'b1),
                         ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(8192)),
                         {random_field(1'b1), random_field(1'b1), random_field(1'b0),
                          random_field(1'b0)});
            stall_pct    = (ph % 3 == 0) ? 0 : $urandom_range(60);
            stall_period = $urandom_range(1, 9);
            max_gap      = (ph % 4 == 1) ? 0 : $urandom_range(6);
            for (int n = 0; n < per_phase; n++)
                send_pixel(random_pixel());
            wait_idle();
        end
    endtask

    // Receiver stall pattern: a random share of cycles plus a periodic block.
    always @(posedge clk)
    begin
        stall_cycle  <= stall_cycle + 1;
        graded_stall <= (stall_pct != 0) &&
                        (($urandom_range(99) < stall_pct)
                         || (stall_cycle % (stall_period + 1) == 0));
    end

    always @(posedge clk)
        if (rst_n && graded_valid && !graded_stall) begin
            if (graded_expected.size() == 0) begin
                $display("%0t: graded word %h with none expected", $time, graded);
                fail_count++;
            end else begin
                pix_out_t e;
                e = graded_expected.pop_front();
                if (graded.red_out !== e.red_out) begin
                    $display("%0t: red_out expected %0d actual %0d", $time, e.red_out,
                             graded.red_out);
                    fail_count++;
                end
                if (graded.green_out !== e.green_out) begin
                    $display("%0t: green_out expected %0d actual %0d", $time, e.green_out,
                             graded.green_out);
                    fail_count++;
                end
                if (graded.blue_out !== e.blue_out) begin
                    $display("%0t: blue_out expected %0d actual %0d", $time, e.blue_out,
                             graded.blue_out);
                    fail_count++;
                end
                words_checked++;
            end
        end

    always @(posedge clk) begin
        if ((pixel_valid && !pixel_stall) || (graded_valid && !graded_stall) || cfg_we
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        grade_regs[REG_LIFT]      = 64'h0;
        grade_regs[REG_INV_GAMMA] = 64'h1000_1000_1000;
        grade_regs[REG_GAIN]      = 64'h1000_1000_1000;
        grade_regs[REG_SHADOW]    = 64'h0;
        grade_regs[REG_MIDTONE]   = 64'h0;
        grade_regs[REG_HIGHLIGHT] = 64'h0;
        grade_regs[REG_EXPOSURE]  = 64'h1000;
        grade_regs[REG_TONE]      = 64'h1000_1000;
        build_pow_tables();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_neutral_extremes();
        max_gap   = 3;
        stall_pct = 30;
        test_gamma_cases();
        test_tone_cases();
        test_random_phases(10, 175);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Graded %0d pixels over directed gamma and tone cases and 10 register sets,",
                 pixels_sent);
        $display("with random sender gaps and receiver stalls; %0d words checked.",
                 words_checked);
        if (fail_count == 0 && graded_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/cgp_pkg.sv
rtl/cgp_chan.sv
rtl/cgp_tone.sv
rtl/rgb_color_grading_pipeline_unit.sv
rtl/cgp_checker.sv
bench/rgb_color_grading_pipeline_unit_tb.sv
